>>> rtl/block_grid_index_remap_macros.svh
// assertion helpers used by the top-level rtl
`ifndef BLOCK_GRID_INDEX_REMAP_MACROS_SVH
`define BLOCK_GRID_INDEX_REMAP_MACROS_SVH

// checked only out of reset
`define BGIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BGIR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bgir_pkg.sv
package bgir_pkg;

	localparam int IDX_W    = 48;
	localparam int HALF_W   = 24;
	localparam int FIELD_W  = 16;
	localparam int CMD_W    = 2;
	localparam int FACE_W   = 6;
	localparam int REG_IDX_W = 2;
	localparam int AXES     = 3;

	localparam logic [IDX_W-1:0] GRID_DIMS_RST = 48'h0001_0001_0001;

	typedef enum logic [CMD_W-1:0] {
		CMD_G2L = 2'd0,
		CMD_L2G = 2'd1,
		CMD_XYZ = 2'd2,
		CMD_BND = 2'd3
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		CFG_GRID_DIMS  = 2'd0,
		CFG_BLOCK_LOW  = 2'd1,
		CFG_BLOCK_HIGH = 2'd2
	} cfg_reg_t;

endpackage

>>> rtl/bgir_req_if.sv
interface bgir_req_if
	import bgir_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [IDX_W-1:0]    index_in;
	logic [FIELD_W-1:0]  coord_x;
	logic [FIELD_W-1:0]  coord_y;
	logic [FIELD_W-1:0]  coord_z;

	modport source (output valid, cmd, index_in, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, cmd, index_in, coord_x, coord_y, coord_z, output ready);
endinterface

>>> rtl/bgir_rsp_if.sv
interface bgir_rsp_if
	import bgir_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   index_out;
	logic               out_of_block;
	logic               on_inner_face;
	logic [FACE_W-1:0]  face_mask;

	modport source (output valid, index_out, out_of_block, on_inner_face, face_mask,
		input ready);
	modport sink (input valid, index_out, out_of_block, on_inner_face, face_mask,
		output ready);
endinterface

>>> rtl/bgir_div.sv
// one quotient bit per stage, restoring division of an index by a small divisor
module bgir_div
	import bgir_pkg::*;
#(
	parameter int DW = 17,
	parameter int SW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IDX_W-1:0]  dividend,
	input  logic [DW-1:0]     divisor,
	input  logic [SW-1:0]     side_in,
	output logic              out_valid,
	output logic [IDX_W-1:0]  quot,
	output logic [DW-1:0]     rem,
	output logic [SW-1:0]     side_out
);

	logic [IDX_W-1:0] x_s   [0:IDX_W];
	logic [DW-1:0]    rem_s [0:IDX_W];
	logic [DW-1:0]    dv_s  [0:IDX_W];
	logic [SW-1:0]    sd_s  [0:IDX_W];
	logic [IDX_W:0]   v_s;

	assign x_s[0]   = dividend;
	assign rem_s[0] = '0;
	assign dv_s[0]  = divisor;
	assign sd_s[0]  = side_in;
	assign v_s[0]   = in_valid;

	for (genvar k = 0; k < IDX_W; k++) begin : g_stage
		logic [DW:0]   trial;
		logic          take;
		logic [DW-1:0] nrem;

		// shift in the next dividend bit and try the subtract
		always_comb begin
			trial = {rem_s[k], x_s[k][IDX_W-1]};
			take  = trial >= {1'b0, dv_s[k]};
			nrem  = take ? DW'(trial - {1'b0, dv_s[k]}) : trial[DW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]   <= {x_s[k][IDX_W-2:0], take};
				rem_s[k+1] <= nrem;
				dv_s[k+1]  <= dv_s[k];
				sd_s[k+1]  <= sd_s[k];
			end
		end
	end

	assign out_valid = v_s[IDX_W];
	assign quot      = x_s[IDX_W];
	assign rem       = rem_s[IDX_W];
	assign side_out  = sd_s[IDX_W];

endmodule

>>> rtl/bgir_recomb.sv
// coordinate fix-up, flags and relinearization with split multiplies
module bgir_recomb
	import bgir_pkg::*;
#(
	parameter int FW = 16,
	parameter int DW = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [CMD_W-1:0]            cmd_in,
	input  logic [DW-1:0]               r0,
	input  logic [DW-1:0]               r1,
	input  logic [IDX_W-1:0]            q2,
	input  logic [FW-1:0]               cx,
	input  logic [FW-1:0]               cy,
	input  logic [FW-1:0]               cz,
	input  logic [AXES-1:0][FW-1:0]     dim,
	input  logic [AXES-1:0][FW-1:0]     dim_m1,
	input  logic [AXES-1:0][DW-1:0]     ext,
	input  logic [AXES-1:0][FW-1:0]     lo,
	input  logic [AXES-1:0][FW-1:0]     hi,
	input  logic [FACE_W-1:0]           mask,
	output logic                        out_valid,
	output logic [IDX_W-1:0]            index_out,
	output logic                        out_of_block,
	output logic                        on_inner_face,
	output logic [FACE_W-1:0]           face_mask
);

	localparam int PW = HALF_W + DW;

	cmd_t             cmd;
	logic [IDX_W-1:0] a0, a1, a2;
	logic [DW-1:0]    m0, m1;
	logic             oob, inner;

	// stage 1
	logic              v_s1, zero_s1, oob_s1, inner_s1;
	logic [IDX_W-1:0]  a0_s1, a1_s1, a2_s1;
	logic [DW-1:0]     m0_s1, m1_s1;
	logic [FACE_W-1:0] mask_s1;
	// stage 2
	logic              v_s2, zero_s2, oob_s2, inner_s2;
	logic [PW-1:0]     pl_s2;
	logic [HALF_W-1:0] ph_s2;
	logic [IDX_W-1:0]  a0_s2, a1_s2;
	logic [DW-1:0]     m0_s2;
	logic [FACE_W-1:0] mask_s2;
	logic [PW-1:0]     ph_full2;
	// stage 3
	logic              v_s3, zero_s3, oob_s3, inner_s3;
	logic [IDX_W-1:0]  t_s3, a0_s3;
	logic [DW-1:0]     m0_s3;
	logic [FACE_W-1:0] mask_s3;
	// stage 4
	logic              v_s4, zero_s4, oob_s4, inner_s4;
	logic [PW-1:0]     pl_s4;
	logic [HALF_W-1:0] ph_s4;
	logic [IDX_W-1:0]  a0_s4;
	logic [FACE_W-1:0] mask_s4;
	logic [PW-1:0]     ph_full4;
	// output register
	logic              valid_q, oob_q, inner_q;
	logic [IDX_W-1:0]  index_q;
	logic [FACE_W-1:0] mask_q;

	assign cmd = cmd_t'(cmd_in);

	// per-command coordinates and relinearization sizes
	always_comb begin
		unique case (cmd)
			CMD_G2L: begin
				a0 = IDX_W'(r0) - IDX_W'(lo[0]);
				a1 = IDX_W'(r1) - IDX_W'(lo[1]);
				a2 = q2 - IDX_W'(lo[2]);
				m0 = ext[0];
				m1 = ext[1];
			end
			CMD_L2G: begin
				a0 = IDX_W'(r0 + DW'(lo[0]));
				a1 = IDX_W'(r1 + DW'(lo[1]));
				a2 = q2 + IDX_W'(lo[2]);
				m0 = DW'(dim[0]);
				m1 = DW'(dim[1]);
			end
			CMD_XYZ: begin
				a0 = IDX_W'(cx);
				a1 = IDX_W'(cy);
				a2 = IDX_W'(cz);
				m0 = DW'(dim[0]);
				m1 = DW'(dim[1]);
			end
			CMD_BND: begin
				a0 = IDX_W'(r0);
				a1 = IDX_W'(r1);
				a2 = q2;
				m0 = DW'(dim[0]);
				m1 = DW'(dim[1]);
			end
		endcase
	end

	// outside-block and inner-face flags
	always_comb begin
		oob = (cmd == CMD_G2L) && (
			(r0 < DW'(lo[0])) || (r0 > DW'(hi[0])) ||
			(r1 < DW'(lo[1])) || (r1 > DW'(hi[1])) ||
			(q2 < IDX_W'(lo[2])) || (q2 > IDX_W'(hi[2])));
		inner = (cmd == CMD_BND) && (
			((r0 != '0) && (r0 != DW'(dim_m1[0])) &&
				((r0 == DW'(lo[0])) || (r0 == DW'(hi[0])))) ||
			((r1 != '0) && (r1 != DW'(dim_m1[1])) &&
				((r1 == DW'(lo[1])) || (r1 == DW'(hi[1])))) ||
			((q2 != '0) && (q2 != IDX_W'(dim_m1[2])) &&
				((q2 == IDX_W'(lo[2])) || (q2 == IDX_W'(hi[2])))));
	end

	assign ph_full2 = a2_s1[IDX_W-1:HALF_W] * PW'(m1_s1);
	assign ph_full4 = t_s3[IDX_W-1:HALF_W] * PW'(m0_s3);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= v_s4;
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		if (en) begin
			a0_s1    <= a0;
			a1_s1    <= a1;
			a2_s1    <= a2;
			m0_s1    <= m0;
			m1_s1    <= m1;
			zero_s1  <= (cmd == CMD_BND);
			oob_s1   <= oob;
			inner_s1 <= inner;
			mask_s1  <= mask;

			// z times y size, in two halves
			pl_s2    <= PW'(a2_s1[HALF_W-1:0]) * PW'(m1_s1);
			ph_s2    <= ph_full2[HALF_W-1:0];
			a0_s2    <= a0_s1;
			a1_s2    <= a1_s1;
			m0_s2    <= m0_s1;
			zero_s2  <= zero_s1;
			oob_s2   <= oob_s1;
			inner_s2 <= inner_s1;
			mask_s2  <= mask_s1;

			// add y
			t_s3     <= IDX_W'(pl_s2) + {ph_s2, HALF_W'(0)} + a1_s2;
			a0_s3    <= a0_s2;
			m0_s3    <= m0_s2;
			zero_s3  <= zero_s2;
			oob_s3   <= oob_s2;
			inner_s3 <= inner_s2;
			mask_s3  <= mask_s2;

			// times x size, in two halves
			pl_s4    <= PW'(t_s3[HALF_W-1:0]) * PW'(m0_s3);
			ph_s4    <= ph_full4[HALF_W-1:0];
			a0_s4    <= a0_s3;
			zero_s4  <= zero_s3;
			oob_s4   <= oob_s3;
			inner_s4 <= inner_s3;
			mask_s4  <= mask_s3;

			// add x, boundary test gives zero
			index_q  <= zero_s4 ? '0 : IDX_W'(pl_s4) + {ph_s4, HALF_W'(0)} + a0_s4;
			oob_q    <= oob_s4;
			inner_q  <= inner_s4;
			mask_q   <= mask_s4;
		end
	end

	assign out_valid     = valid_q;
	assign index_out     = index_q;
	assign out_of_block  = oob_q;
	assign on_inner_face = inner_q;
	assign face_mask     = mask_q;

endmodule

>>> rtl/block_grid_index_remap.sv
// Row-major index conversion between a 3D grid and a sub-block of it.
// Items enter on req (valid/ready) with a command, a linear index and x/y/z;
// results leave on rsp with the converted index, the out-of-block and
// inner-face flags and the mask of block faces lying on the domain edge.
// Grid sizes and the block corners are written through cfg_wen/cfg_index/
// cfg_data while no item is in flight; sizes of zero count as one.
// From accept to result valid an item passes two 48-stage divider pipelines
// (one quotient bit per stage) and five stages of coordinate fix-up and
// split multiply-add. One item per cycle is taken while rsp takes its
// results. The whole pipeline advances together: when rsp holds a result
// that is not taken, every stage holds and req.ready drops, so nothing is
// lost or repeated. Reset clears all valid bits and loads a 1x1x1 grid with
// a block at the origin; the registers are usable in the first cycle.
module block_grid_index_remap
	import bgir_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [IDX_W-1:0]      cfg_data,
	bgir_req_if.sink              req,
	bgir_rsp_if.source            rsp
);

`include "block_grid_index_remap_macros.svh"

	localparam int FW  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int DW  = FW + 1;
	localparam int SWA = CMD_W + AXES * FW;
	localparam int SWB = SWA + DW;

	logic [IDX_W-1:0] grid_q, low_q, high_q;

	logic [AXES-1:0][FW-1:0] dim, dim_m1, lo, hi;
	logic [AXES-1:0][DW-1:0] ext;
	logic [FACE_W-1:0]       mask;

	logic             en;
	logic [DW-1:0]    div_a, div_b;
	logic [SWA-1:0]   side_a, side_a_out;
	logic [SWB-1:0]   side_b_out;
	logic             va, vb;
	logic [IDX_W-1:0] q1, q2;
	logic [DW-1:0]    r0, r1, r0_b;
	logic [CMD_W-1:0] cmd_a, cmd_b;
	logic [FW-1:0]    cx_b, cy_b, cz_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= GRID_DIMS_RST;
			low_q  <= '0;
			high_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_GRID_DIMS:  grid_q <= cfg_data;
				CFG_BLOCK_LOW:  low_q  <= cfg_data;
				CFG_BLOCK_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-axis sizes, extents and edge faces
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			dim[a]    = (grid_q[FIELD_W*a +: FW] == '0) ? FW'(1) : grid_q[FIELD_W*a +: FW];
			dim_m1[a] = dim[a] - FW'(1);
			lo[a]     = low_q[FIELD_W*a +: FW];
			hi[a]     = high_q[FIELD_W*a +: FW];
			ext[a]    = (hi[a] >= lo[a]) ? DW'(hi[a] - lo[a]) + DW'(1) : DW'(1);
			mask[2*a]   = (lo[a] == '0);
			mask[2*a+1] = (hi[a] == dim_m1[a]);
		end
	end

	// global stall when the result is not taken
	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// first split: x and the rest
	assign div_a  = (cmd_t'(req.cmd) == CMD_L2G) ? ext[0] : DW'(dim[0]);
	assign side_a = {req.cmd, req.coord_x[FW-1:0], req.coord_y[FW-1:0],
		req.coord_z[FW-1:0]};

	bgir_div #(.DW(DW), .SW(SWA)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req.valid),
		.dividend (req.index_in),
		.divisor  (div_a),
		.side_in  (side_a),
		.out_valid(va),
		.quot     (q1),
		.rem      (r0),
		.side_out (side_a_out)
	);

	// second split: y and z
	assign cmd_a = side_a_out[SWA-1 -: CMD_W];
	assign div_b = (cmd_t'(cmd_a) == CMD_L2G) ? ext[1] : DW'(dim[1]);

	bgir_div #(.DW(DW), .SW(SWB)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (va),
		.dividend (q1),
		.divisor  (div_b),
		.side_in  ({side_a_out, r0}),
		.out_valid(vb),
		.quot     (q2),
		.rem      (r1),
		.side_out (side_b_out)
	);

	assign r0_b  = side_b_out[DW-1:0];
	assign cz_b  = side_b_out[DW +: FW];
	assign cy_b  = side_b_out[DW+FW +: FW];
	assign cx_b  = side_b_out[DW+2*FW +: FW];
	assign cmd_b = side_b_out[SWB-1 -: CMD_W];

	bgir_recomb #(.FW(FW), .DW(DW)) u_recomb (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (vb),
		.cmd_in       (cmd_b),
		.r0           (r0_b),
		.r1           (r1),
		.q2           (q2),
		.cx           (cx_b),
		.cy           (cy_b),
		.cz           (cz_b),
		.dim          (dim),
		.dim_m1       (dim_m1),
		.ext          (ext),
		.lo           (lo),
		.hi           (hi),
		.mask         (mask),
		.out_valid    (rsp.valid),
		.index_out    (rsp.index_out),
		.out_of_block (rsp.out_of_block),
		.on_inner_face(rsp.on_inner_face),
		.face_mask    (rsp.face_mask)
	);

	// checks
	`BGIR_ASSERT(a_flags_excl, !(rsp.valid && rsp.out_of_block && rsp.on_inner_face), "both flags set")
	`BGIR_ASSERT(a_inner_zero, (rsp.valid && rsp.on_inner_face) |-> (rsp.index_out == '0), "inner face with index")
	`BGIR_ASSERT(a_mask_cfg, (rsp.valid && !$past(cfg_wen)) |-> (rsp.face_mask == mask), "face mask stale")
	`BGIR_ASSERT_ALWAYS(a_ready_rule, req.ready === (!rsp.valid || rsp.ready), "ready mismatch")

endmodule
